// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define FRSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FRSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/frsa_pkg.sv =====
// types and constants of the fused risk score alert core
package frsa_pkg;

  localparam int WIN_DEPTH_DEF = 16;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [14:0] EYE_START = 15'd15360;
  localparam logic [14:0] EYE_FULL  = 15'd25600;
  localparam logic [14:0] EYE_HARD  = 15'd24320;
  localparam logic [15:0] HEART_HARD = 16'd7680;
  localparam logic [16:0] ACCEL_DANGER_MARGIN = 17'd4096;
  // d*d*65536/10240^2 reduces to d*d/1600
  localparam logic [17:0] EYE_DIV   = 18'd1600;
  localparam logic [35:0] EYE_HALF  = 36'd800;

  localparam int DVD_W = 36;
  localparam int DVS_W = 18;
  localparam int ACC_W = 35;

  localparam logic [2:0] REG_THRESHOLD    = 3'd0;
  localparam logic [2:0] REG_OCULAR_WT    = 3'd1;
  localparam logic [2:0] REG_HEART_WEIGHT = 3'd2;
  localparam logic [2:0] REG_MOTION_WEIGHT = 3'd3;
  localparam logic [2:0] REG_ACCEL_BASE   = 3'd4;
  localparam logic [2:0] REG_ACCEL_MARGIN = 3'd5;
  localparam logic [2:0] REG_HEART_SAFE   = 3'd6;
  localparam logic [2:0] REG_HEART_DANGER = 3'd7;

  typedef struct packed {
    logic [16:0] alert_threshold;
    logic [15:0] ocular_wt;
    logic [15:0] heart_weight;
    logic [15:0] motion_weight;
    logic [15:0] accel_baseline;
    logic [15:0] accel_safe_margin;
    logic [14:0] heart_safe_level;
    logic [14:0] heart_danger_level;
  } cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic        hard;
    logic        eye_full;
    logic        eye_ramp;
    logic [13:0] eye_d;
    logic        hrt_full;
    logic        hrt_ramp;
    logic [14:0] hrt_diff;
    logic [14:0] hrt_den;
    logic        acc_full;
    logic        acc_ramp;
    logic [16:0] acc_diff;
    logic [16:0] acc_den;
  } item_t;

  typedef struct packed {
    logic        alert;
    logic [16:0] avg_score;
  } res_t;

endpackage

// ===== rtl/core/frsa_fifo.sv =====
// two-entry queue used between front and back and at the result side
module frsa_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== rtl/core/frsa_front.sv =====
// front end: classifies a sample into ramp/full/zero cases per feature and flags hard limits
module frsa_front (
  input  frsa_pkg::cfg_t  cfg,
  input  logic [14:0]     eye_closed_pct,
  input  logic [15:0]     heart_change,
  input  logic [15:0]     accel_level,
  output frsa_pkg::item_t item
);
  import frsa_pkg::*;

  logic [15:0] habs;
  logic [15:0] acc_lvl;
  logic [16:0] acc_safe, acc_danger;
  logic        hrt_above, acc_above;

  always_comb begin
    habs = heart_change[15] ? (16'd0 - heart_change) : heart_change;
    acc_lvl = (accel_level == 16'd0) ? cfg.accel_baseline : accel_level;
    acc_safe   = {1'b0, cfg.accel_baseline} + {1'b0, cfg.accel_safe_margin};
    acc_danger = {1'b0, cfg.accel_baseline} + ACCEL_DANGER_MARGIN;
    hrt_above = habs > {1'b0, cfg.heart_safe_level};
    acc_above = {1'b0, acc_lvl} > acc_safe;

    item.hard = (eye_closed_pct >= EYE_HARD) || (habs >= HEART_HARD);

    item.eye_full = eye_closed_pct >= EYE_FULL;
    item.eye_ramp = !item.eye_full && (eye_closed_pct > EYE_START);
    item.eye_d    = 14'(eye_closed_pct - EYE_START);

    item.hrt_full = hrt_above && (habs >= {1'b0, cfg.heart_danger_level});
    item.hrt_ramp = hrt_above && !item.hrt_full;
    item.hrt_diff = 15'(habs - {1'b0, cfg.heart_safe_level});
    item.hrt_den  = cfg.heart_danger_level - cfg.heart_safe_level;

    item.acc_full = acc_above && ({1'b0, acc_lvl} >= acc_danger);
    item.acc_ramp = acc_above && !item.acc_full;
    item.acc_diff = {1'b0, acc_lvl} - acc_safe;
    item.acc_den  = acc_danger - acc_safe;
  end

endmodule

// ===== rtl/core/frsa_div.sv =====
// shared serial divider, two quotient bits per cycle, 18-bit quotient
module frsa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [frsa_pkg::DVD_W-1:0] dividend,
  input  logic [frsa_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [frsa_pkg::DVS_W-1:0] quotient
);
  import frsa_pkg::*;

  // dividend must be below divisor << DVS_W
  logic [DVS_W-1:0] rem_r, low_r, q_r, dvs_r;
  logic [DVS_W-1:0] rem_nxt, low_nxt, q_nxt;
  logic [3:0]       cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   t;

  always_comb begin
    rem_nxt = rem_r;
    low_nxt = low_r;
    q_nxt   = q_r;
    t       = '0;
    for (int i = 0; i < 2; i++) begin
      t = {rem_nxt, low_nxt[DVS_W-1]};
      low_nxt = {low_nxt[DVS_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(t - {1'b0, dvs_r});
        q_nxt   = {q_nxt[DVS_W-2:0], 1'b1};
      end else begin
        rem_nxt = t[DVS_W-1:0];
        q_nxt   = {q_nxt[DVS_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'(DVS_W / 2);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DVD_W-1:DVS_W];
      low_r <= dividend[DVS_W-1:0];
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/core/frsa_back.sv =====
// back end: feature divisions, weighted fusion, window average and alert
module frsa_back #(
  parameter int WIN_DEPTH = frsa_pkg::WIN_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  frsa_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  frsa_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            oq_full,
  output logic            oq_push,
  output frsa_pkg::res_t  oq_res
);
  import frsa_pkg::*;

  localparam int TOT_W  = $clog2(WIN_DEPTH * 65536 + 1);
  localparam int CNT_W  = $clog2(WIN_DEPTH + 1);
  localparam int SLOT_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_EYE_SQ   = 4'd1;
  localparam logic [3:0] ST_EYE_DIV  = 4'd2;
  localparam logic [3:0] ST_HRT_DIV  = 4'd3;
  localparam logic [3:0] ST_ACC_DIV  = 4'd4;
  localparam logic [3:0] ST_MAC      = 4'd5;
  localparam logic [3:0] ST_FUSE_DIV = 4'd6;
  localparam logic [3:0] ST_WIN      = 4'd7;
  localparam logic [3:0] ST_AVG_DIV  = 4'd8;
  localparam logic [3:0] ST_OUT      = 4'd9;

  logic [3:0]        st_r;
  logic              started_r;
  item_t             item_r;
  logic [27:0]       prod_r;
  logic [16:0]       f_eye_r, f_hrt_r, f_acc_r, fused_r, avg_r, old_r;
  logic [ACC_W-1:0]  acc_r;
  logic [1:0]        k_r;
  logic [TOT_W-1:0]  total_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  fill_r;
  logic [16:0]       win_mem [WIN_DEPTH];

  logic              div_start, div_done, need_div, is_div_st, is_full;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs, quo;
  logic [17:0]       wsum;
  logic [15:0]       mac_w;
  logic [16:0]       mac_f, old_val, fix_val;

  assign q_pop   = (st_r == ST_IDLE) && !q_empty;
  assign oq_push = (st_r == ST_OUT) && !oq_full;
  assign oq_res.avg_score = avg_r;
  assign oq_res.alert = item_r.hard || (avg_r >= cfg.alert_threshold);

  assign old_val = (fill_r < CNT_W'(WIN_DEPTH)) ? 17'd0 : old_r;

  always_comb begin
    wsum = {2'b0, cfg.ocular_wt} + {2'b0, cfg.heart_weight} + {2'b0, cfg.motion_weight};
    if (wsum == 18'd0) wsum = 18'd1;
    need_div  = 1'b1;
    is_div_st = 1'b1;
    is_full   = 1'b0;
    dvd = '0;
    dvs = 18'd1;
    case (st_r)
      ST_EYE_DIV: begin
        need_div = item_r.eye_ramp;
        is_full  = item_r.eye_full;
        dvd = DVD_W'(prod_r) + EYE_HALF;
        dvs = EYE_DIV;
      end
      ST_HRT_DIV: begin
        need_div = item_r.hrt_ramp;
        is_full  = item_r.hrt_full;
        dvd = DVD_W'({item_r.hrt_diff, 16'b0}) + DVD_W'(item_r.hrt_den >> 1);
        dvs = DVS_W'(item_r.hrt_den);
      end
      ST_ACC_DIV: begin
        need_div = item_r.acc_ramp;
        is_full  = item_r.acc_full;
        dvd = DVD_W'({item_r.acc_diff, 16'b0}) + DVD_W'(item_r.acc_den >> 1);
        dvs = DVS_W'(item_r.acc_den);
      end
      ST_FUSE_DIV: begin
        dvd = DVD_W'(acc_r) + DVD_W'(wsum >> 1);
        dvs = wsum;
      end
      ST_AVG_DIV: begin
        dvd = DVD_W'(total_r) + DVD_W'(fill_r >> 1);
        dvs = DVS_W'(fill_r);
      end
      default: is_div_st = 1'b0;
    endcase
    fix_val   = is_full ? ONE_Q16 : 17'd0;
    div_start = is_div_st && need_div && !started_r;
  end

  always_comb begin
    case (k_r)
      2'd0: begin
        mac_w = cfg.ocular_wt;
        mac_f = f_eye_r;
      end
      2'd1: begin
        mac_w = cfg.heart_weight;
        mac_f = f_hrt_r;
      end
      default: begin
        mac_w = cfg.motion_weight;
        mac_f = f_acc_r;
      end
    endcase
  end

  frsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      started_r <= 1'b0;
      k_r       <= 2'd0;
      total_r   <= '0;
      slot_r    <= '0;
      fill_r    <= '0;
    end else begin
      if (div_start) started_r <= 1'b1;
      case (st_r)
        ST_IDLE: if (!q_empty) st_r <= ST_EYE_SQ;
        ST_EYE_SQ: st_r <= ST_EYE_DIV;
        ST_EYE_DIV, ST_HRT_DIV, ST_ACC_DIV, ST_FUSE_DIV, ST_AVG_DIV: begin
          if (!need_div || (started_r && div_done)) begin
            started_r <= 1'b0;
            case (st_r)
              ST_EYE_DIV:  st_r <= ST_HRT_DIV;
              ST_HRT_DIV:  st_r <= ST_ACC_DIV;
              ST_ACC_DIV:  st_r <= ST_MAC;
              ST_FUSE_DIV: st_r <= ST_WIN;
              default:     st_r <= ST_OUT;
            endcase
          end
        end
        ST_MAC: begin
          if (k_r == 2'd2) begin
            k_r  <= 2'd0;
            st_r <= ST_FUSE_DIV;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        ST_WIN: begin
          total_r <= total_r - TOT_W'(old_val) + TOT_W'(fused_r);
          slot_r  <= (slot_r == SLOT_W'(WIN_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
          if (fill_r < CNT_W'(WIN_DEPTH)) fill_r <= fill_r + CNT_W'(1);
          st_r <= ST_AVG_DIV;
        end
        ST_OUT: if (!oq_full) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      old_r  <= win_mem[slot_r];
    end
    if (st_r == ST_EYE_SQ) prod_r <= item_r.eye_d * item_r.eye_d;
    if (st_r == ST_MAC) begin
      acc_r <= ((k_r == 2'd0) ? '0 : acc_r) + ACC_W'(mac_w * mac_f);
    end
    if (st_r == ST_WIN) win_mem[slot_r] <= fused_r;
    if (is_div_st && (!need_div || (started_r && div_done))) begin
      case (st_r)
        ST_EYE_DIV:  f_eye_r <= need_div ? quo[16:0] : fix_val;
        ST_HRT_DIV:  f_hrt_r <= need_div ? quo[16:0] : fix_val;
        ST_ACC_DIV:  f_acc_r <= need_div ? quo[16:0] : fix_val;
        ST_FUSE_DIV: fused_r <= quo[16:0];
        default:     avg_r   <= quo[16:0];
      endcase
    end
  end

endmodule

// ===== rtl/core/fused_risk_score_alert_core.sv =====
// shared divider: fusion and average always divide, each feature on its ramp
// the back end takes a new sample only once its last result is queued
// a two-beat queue at each side lets front and back stall
// reset: synchronous active-low rst_n clears queues, window fill count and config registers to defaults
// window store holds no reset; slots not yet filled read as zero through the fill count
module fused_risk_score_alert_core #(
  parameter int WIN_DEPTH = frsa_pkg::WIN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [14:0] in_eye_closed_pct,
  input  logic signed [15:0] in_heart_change,
  input  logic [15:0] in_accel_level,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_alert,
  output logic [16:0] out_avg_score,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [16:0] cfg_wdata
);
  import frsa_pkg::*;
  `include "assert_macros.svh"

  cfg_t  cfg_r;
  item_t fr_item, q_item;
  res_t  oq_res, out_res;
  logic  q_empty, q_full, q_pop, oq_full, oq_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alert_threshold    <= 17'd49152;
      cfg_r.ocular_wt          <= 16'd2458;
      cfg_r.heart_weight       <= 16'd819;
      cfg_r.motion_weight      <= 16'd819;
      cfg_r.accel_baseline     <= 16'd4096;
      cfg_r.accel_safe_margin  <= 16'd2048;
      cfg_r.heart_safe_level   <= 15'd1280;
      cfg_r.heart_danger_level <= 15'd5120;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_THRESHOLD:     cfg_r.alert_threshold    <= cfg_wdata;
        REG_OCULAR_WT:     cfg_r.ocular_wt          <= cfg_wdata[15:0];
        REG_HEART_WEIGHT:  cfg_r.heart_weight       <= cfg_wdata[15:0];
        REG_MOTION_WEIGHT: cfg_r.motion_weight      <= cfg_wdata[15:0];
        REG_ACCEL_BASE:    cfg_r.accel_baseline     <= cfg_wdata[15:0];
        REG_ACCEL_MARGIN:  cfg_r.accel_safe_margin  <= cfg_wdata[15:0];
        REG_HEART_SAFE:    cfg_r.heart_safe_level   <= cfg_wdata[14:0];
        REG_HEART_DANGER:  cfg_r.heart_danger_level <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  frsa_front u_front (
    .cfg            (cfg_r),
    .eye_closed_pct (in_eye_closed_pct),
    .heart_change   (in_heart_change),
    .accel_level    (in_accel_level),
    .item           (fr_item)
  );

  frsa_fifo #(.W($bits(item_t))) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (fr_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  assign in_full = q_full;

  frsa_back #(.WIN_DEPTH(WIN_DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_res  (oq_res)
  );

  frsa_fifo #(.W($bits(res_t))) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_res),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_alert     = out_res.alert;
  assign out_avg_score = out_res.avg_score;

  `FRSA_ASSERT(a_avg_range, clk, rst_n, !out_empty |-> (out_avg_score <= ONE_Q16), "average above one")
  `FRSA_ASSERT(a_beat_queued, clk, rst_n, (in_push && !in_full) |=> !q_empty, "accepted beat lost")
  `FRSA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (out_empty && !in_full), "queues not cleared")

endmodule
